### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers for the controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, suspended while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error(msg);

`endif

### sv/dssc_pkg.sv
// ----------------------------------------------------------------------------
// Slot stack controller package
// Transaction payload types, request kinds and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package dssc_pkg;

   localparam int THR_W             = 8;
   localparam int CSR_IDX_W         = 2;
   localparam int SENSOR_W          = 4;
   localparam logic [THR_W-1:0] DEFAULT_THRESHOLD = 8'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_FILL_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAIN_THRESHOLD = 2'd1;

   typedef enum logic [2:0] {
      KIND_TICK         = 3'd0,
      KIND_PUSH_REQ     = 3'd1,
      KIND_POP_REQ      = 3'd2,
      KIND_CONFIRM_PUSH = 3'd3,
      KIND_CONFIRM_POP  = 3'd4,
      KIND_CANCEL_PUSH  = 3'd5,
      KIND_SET_TYPE     = 3'd6
   } kind_type;

   localparam logic [1:0] STATUS_EMPTY = 2'd0;
   localparam logic [1:0] STATUS_SPACE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]          kind;
      logic [SENSOR_W-1:0] sensor_levels;
      logic                machine_disabled;
      logic [1:0]          item_type;
      logic [1:0]          query_slot;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]          stack_status;
      logic [1:0]          target_slot;
      logic                slot_found;
      logic [SENSOR_W-1:0] pump_drive;
      logic [SENSOR_W-1:0] valve_drive;
      logic [2:0]          occupied_count;
      logic [SENSOR_W-1:0] occupied_mask;
      logic [1:0]          grab_type;
      logic [1:0]          queried_type;
   } rsp_payload_type;

   // Broadcast command to every slot lane.
   typedef struct packed {
      logic tick;
      logic disabled;
      logic confirm_push;
      logic drop;
   } lane_cmd_type;

endpackage

`default_nettype wire

### sv/dssc_slot_lane.sv
// ----------------------------------------------------------------------------
// Slot lane
// Per-slot debounce counters, occupancy, suction flag and stored item type.
// ----------------------------------------------------------------------------
`default_nettype none

module dssc_slot_lane
   import dssc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lane_cmd_type     cmd,
   input  wire logic             sel,
   input  wire logic             sensor,
   input  wire logic [THR_W-1:0] fill_threshold,
   input  wire logic [THR_W-1:0] drain_threshold,
   input  wire logic [1:0]       latest_type,
   output logic                  occupied,
   output logic                  suction,
   output logic [1:0]            item_type
);

   logic             occ_ff, occ_in;
   logic             suct_ff, suct_in;
   logic [THR_W-1:0] fill_ff, fill_in;
   logic [THR_W-1:0] drain_ff, drain_in;
   logic [1:0]       type_ff, type_in;
   logic             occ_mid;

   always_comb begin
      occ_in   = occ_ff;
      suct_in  = suct_ff;
      fill_in  = fill_ff;
      drain_in = drain_ff;
      type_in  = type_ff;
      occ_mid  = occ_ff;
      if (cmd.tick) begin
         if (!occ_ff && !sensor) begin
            fill_in = (fill_ff == '1) ? fill_ff : fill_ff + 1'b1;
            if (fill_in >= fill_threshold) occ_mid = 1'b1;
         end else begin
            fill_in = '0;
         end
         occ_in = occ_mid;
         if (occ_mid && sensor) begin
            drain_in = (drain_ff == '1) ? drain_ff : drain_ff + 1'b1;
            if (drain_in >= drain_threshold) occ_in = 1'b0;
         end else begin
            drain_in = '0;
         end
         if (occ_ff && !occ_in) suct_in = 1'b0;
         if (cmd.disabled) begin
            occ_in   = 1'b0;
            suct_in  = 1'b0;
            fill_in  = '0;
            drain_in = '0;
         end
      end else if (sel && cmd.confirm_push) begin
         type_in = latest_type;
         suct_in = 1'b1;
      end else if (sel && cmd.drop) begin
         suct_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= 1'b0;
         suct_ff  <= 1'b0;
         fill_ff  <= '0;
         drain_ff <= '0;
         type_ff  <= '0;
      end else begin
         occ_ff   <= occ_in;
         suct_ff  <= suct_in;
         fill_ff  <= fill_in;
         drain_ff <= drain_in;
         type_ff  <= type_in;
      end
   end

   assign occupied  = occ_ff;
   assign suction   = suct_ff;
   assign item_type = type_ff;

endmodule

`default_nettype wire

### sv/dssc_merge.sv
// ----------------------------------------------------------------------------
// Lane merge
// Combines lane occupancy into highest used slot, push/pop targets and count.
// ----------------------------------------------------------------------------
`default_nettype none

module dssc_merge #(
   parameter int SLOT_COUNT = 4,
   parameter int TGT_W      = 2,
   parameter int CNT_W      = 3
) (
   input  wire logic [SLOT_COUNT-1:0] occupied_vec,
   output logic                       any_used,
   output logic                       top_used,
   output logic [TGT_W-1:0]           push_slot,
   output logic [TGT_W-1:0]           pop_slot,
   output logic [CNT_W-1:0]           used_count
);

   always_comb begin
      pop_slot   = '0;
      used_count = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (occupied_vec[i]) begin
            pop_slot   = TGT_W'(i);
            used_count = used_count + 1'b1;
         end
      end
   end

   assign any_used  = |occupied_vec;
   assign top_used  = occupied_vec[SLOT_COUNT-1];
   // lowest slot with nothing above it: one past the highest used slot
   assign push_slot = any_used ? TGT_W'(pop_slot + 1'b1) : '0;

endmodule

`default_nettype wire

### sv/debounced_slot_stack_controller.sv
// ----------------------------------------------------------------------------
// Debounced slot stack controller
// Responses are registered: rsp_valid rises in the cycle after the request is accepted.
// Throughput: one transaction per cycle; a waiting response holds off the next
// request only until it is taken, since req_ready follows rsp_ready combinationally.
// Reset: synchronous, active high; slots empty, thresholds back to 10.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module debounced_slot_stack_controller
   import dssc_pkg::*;
#(
   parameter int SLOT_COUNT = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_payload_type      req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [THR_W-1:0]     csr_wdata
);

   localparam int TGT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   logic [THR_W-1:0] fill_th_ff, drain_th_ff;
   logic [TGT_W-1:0] target_ff, target_in;
   logic [1:0]       latest_ff, latest_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             found_ff, found_in;
   logic [1:0]       query_ff;

   lane_cmd_type    cmd;
   logic            accept;
   logic [SLOT_COUNT-1:0] occ_vec, suct_vec;
   logic [1:0]      type_vec [SLOT_COUNT];
   logic [SENSOR_W-1:0] pump_bits, valve_bits, mask_bits;
   logic            slots_set;

   logic             any_used, top_used;
   logic [TGT_W-1:0] push_slot, pop_slot;
   logic [CNT_W-1:0] used_count;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign cmd.tick         = accept && (req_payload.kind == KIND_TICK);
   assign cmd.disabled     = req_payload.machine_disabled;
   assign cmd.confirm_push = accept && (req_payload.kind == KIND_CONFIRM_PUSH);
   assign cmd.drop         = accept && ((req_payload.kind == KIND_CONFIRM_POP) ||
                                        (req_payload.kind == KIND_CANCEL_PUSH));

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_lane
      logic lane_sensor;
      if (i < SENSOR_W) begin : g_sens
         assign lane_sensor = req_payload.sensor_levels[i];
      end else begin : g_nosens
         assign lane_sensor = 1'b0;
      end
      dssc_slot_lane u_lane (
         .clock           (clock),
         .reset           (reset),
         .cmd             (cmd),
         .sel             (target_ff == TGT_W'(i)),
         .sensor          (lane_sensor),
         .fill_threshold  (fill_th_ff),
         .drain_threshold (drain_th_ff),
         .latest_type     (latest_ff),
         .occupied        (occ_vec[i]),
         .suction         (suct_vec[i]),
         .item_type       (type_vec[i])
      );
   end

   dssc_merge #(
      .SLOT_COUNT (SLOT_COUNT),
      .TGT_W      (TGT_W),
      .CNT_W      (CNT_W)
   ) u_merge (
      .occupied_vec (occ_vec),
      .any_used     (any_used),
      .top_used     (top_used),
      .push_slot    (push_slot),
      .pop_slot     (pop_slot),
      .used_count   (used_count)
   );

   always_comb begin
      target_in    = target_ff;
      latest_in    = latest_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (accept) begin
         rsp_valid_in = 1'b1;
         found_in     = 1'b0;
         case (req_payload.kind)
            KIND_PUSH_REQ: begin
               if (!top_used) begin
                  target_in = push_slot;
                  found_in  = 1'b1;
               end
            end
            KIND_POP_REQ: begin
               if (any_used) begin
                  target_in = pop_slot;
                  found_in  = 1'b1;
               end
            end
            KIND_CONFIRM_POP: latest_in = type_vec[target_ff];
            KIND_SET_TYPE:    latest_in = req_payload.item_type;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_th_ff   <= DEFAULT_THRESHOLD;
         drain_th_ff  <= DEFAULT_THRESHOLD;
         target_ff    <= '0;
         latest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         target_ff    <= target_in;
         latest_ff    <= latest_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         if (csr_we && (csr_index == CSR_FILL_THRESHOLD))  fill_th_ff  <= csr_wdata;
         if (csr_we && (csr_index == CSR_DRAIN_THRESHOLD)) drain_th_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) query_ff <= req_payload.query_slot;
   end

   for (genvar k = 0; k < SENSOR_W; k++) begin : g_drive
      if (k < SLOT_COUNT) begin : g_live
         assign pump_bits[k]  = suct_vec[k];
         assign valve_bits[k] = !suct_vec[k];
         assign mask_bits[k]  = occ_vec[k];
      end else begin : g_none
         assign pump_bits[k]  = 1'b0;
         assign valve_bits[k] = 1'b0;
         assign mask_bits[k]  = 1'b0;
      end
   end

   always_comb begin
      rsp_payload                = '0;
      rsp_payload.stack_status   = !any_used ? STATUS_EMPTY :
                                   (top_used ? STATUS_FULL : STATUS_SPACE);
      rsp_payload.target_slot    = 2'(target_ff);
      rsp_payload.slot_found     = found_ff;
      rsp_payload.pump_drive     = pump_bits;
      rsp_payload.valve_drive    = valve_bits;
      rsp_payload.occupied_count = 3'(used_count);
      rsp_payload.occupied_mask  = mask_bits;
      rsp_payload.grab_type      = latest_ff;
      rsp_payload.queried_type   = (32'(query_ff) < SLOT_COUNT) ?
                                   type_vec[TGT_W'(query_ff)] : 2'd0;
   end

   assign rsp_valid = rsp_valid_ff;
   assign slots_set = |{suct_vec, occ_vec};

   `ASSERT_CLK(a_stall_only_on_rsp, clock, reset, !req_ready |-> rsp_valid_ff, "request stalled")
   `ASSERT_CLK(a_count_matches_any, clock, reset, (used_count == '0) == !any_used, "bad count")
   `ASSERT_CLK(a_drive_disjoint, clock, reset, (pump_bits & valve_bits) == '0, "drive overlap")
   `ASSERT_NEXT(a_dis_clears, clock, reset, cmd.tick && cmd.disabled, !slots_set, "not cleared")

endmodule

`default_nettype wire

### dv/tb_debounced_slot_stack_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot stack controller testbench
// Sends tick and operator request transactions through the request channel,
// predicts each response from a behavioural model of the debounce counters,
// stack search and suction flags, and checks every response field in order.
// Steps through several threshold settings, including the extremes, with
// random idling on both channels and a long response hold-off.
// ----------------------------------------------------------------------------
module tb_debounced_slot_stack_controller;
   import dssc_pkg::*;

   localparam int NUM_SLOTS = 4;
   localparam int MAX_REPORTS = 10;
   localparam logic [2:0] KIND_SPARE = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [THR_W-1:0] csr_wdata = '0;

   debounced_slot_stack_controller #(.SLOT_COUNT(NUM_SLOTS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #6 clock = ~clock;

   // model state
   logic [THR_W-1:0] fill_thr = DEFAULT_THRESHOLD;
   logic [THR_W-1:0] drain_thr = DEFAULT_THRESHOLD;
   logic [NUM_SLOTS-1:0] slot_used = '0;
   logic [NUM_SLOTS-1:0] suction_on = '0;
   logic [7:0] fill_cnt [NUM_SLOTS] = '{default: '0};
   logic [7:0] drain_cnt [NUM_SLOTS] = '{default: '0};
   logic [1:0] slot_type [NUM_SLOTS] = '{default: '0};
   logic [1:0] target = '0;
   logic [1:0] latest = '0;
   logic [2:0] used_total = '0;

   req_payload_type slot_cmd_queue [$];
   rsp_payload_type expected_stack_rsp [$];
   int mismatch_count = 0;
   int items_queued = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   logic hold_pending = 1'b0;
   logic [3:0] sensor_now = 4'hF;

   function automatic rsp_payload_type predict_stack_response(input req_payload_type cmd);
      rsp_payload_type r;
      logic was;
      logic high;
      logic found;
      logic clear;
      int i;
      int j;
      found = 1'b0;
      case (cmd.kind)
         KIND_TICK: begin
            for (i = 0; i < NUM_SLOTS; i++) begin
               was = slot_used[i];
               high = cmd.sensor_levels[i];
               if (!slot_used[i] && !high) begin
                  if (fill_cnt[i] != 8'hFF) fill_cnt[i]++;
                  if (fill_cnt[i] >= fill_thr) slot_used[i] = 1'b1;
               end else begin
                  fill_cnt[i] = '0;
               end
               if (slot_used[i] && high) begin
                  if (drain_cnt[i] != 8'hFF) drain_cnt[i]++;
                  if (drain_cnt[i] >= drain_thr) slot_used[i] = 1'b0;
               end else begin
                  drain_cnt[i] = '0;
               end
               if (was && !slot_used[i]) suction_on[i] = 1'b0;
            end
            if (cmd.machine_disabled) begin
               slot_used = '0;
               suction_on = '0;
               fill_cnt = '{default: '0};
               drain_cnt = '{default: '0};
            end
            used_total = '0;
            for (i = 0; i < NUM_SLOTS; i++) used_total += slot_used[i];
         end
         KIND_PUSH_REQ: begin
            if (!slot_used[NUM_SLOTS-1]) begin
               for (i = 0; i < NUM_SLOTS; i++) begin
                  clear = !slot_used[i];
                  for (j = i + 1; j < NUM_SLOTS; j++) if (slot_used[j]) clear = 1'b0;
                  if (clear && !found) begin
                     target = 2'(i);
                     found = 1'b1;
                  end
               end
            end
         end
         KIND_POP_REQ: begin
            if (used_total != 0) begin
               for (i = NUM_SLOTS - 1; i >= 0; i--) begin
                  if (slot_used[i] && !found) begin
                     target = 2'(i);
                     found = 1'b1;
                  end
               end
            end
         end
         KIND_CONFIRM_PUSH: begin
            slot_type[target] = latest;
            suction_on[target] = 1'b1;
         end
         KIND_CONFIRM_POP: begin
            latest = slot_type[target];
            suction_on[target] = 1'b0;
         end
         KIND_CANCEL_PUSH: suction_on[target] = 1'b0;
         KIND_SET_TYPE: latest = cmd.item_type;
         default: ;
      endcase
      if (used_total == 0) r.stack_status = STATUS_EMPTY;
      else if (slot_used[NUM_SLOTS-1]) r.stack_status = STATUS_FULL;
      else r.stack_status = STATUS_SPACE;
      r.target_slot = target;
      r.slot_found = found;
      r.pump_drive = suction_on;
      r.valve_drive = ~suction_on;
      r.occupied_count = used_total;
      r.occupied_mask = slot_used;
      r.grab_type = latest;
      r.queried_type = slot_type[cmd.query_slot];
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_stack_rsp.push_back(predict_stack_response(req_payload));
         if (!req_valid || req_ready) begin
            if (slot_cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= slot_cmd_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response side back-pressure
   always @(posedge clock) begin
      if (hold_pending) begin
         hold_left = 300;
         hold_pending <= 1'b0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [3:0] want_v,
                              input logic [3:0] got_v);
      if (want_v !== got_v) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t %s mismatch: expected %0h, got %0h", $realtime, name, want_v, got_v);
      end
   endtask

   // response monitor
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_stack_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t unexpected response %h", $realtime, rsp_payload);
         end else begin
            want = expected_stack_rsp.pop_front();
            check_field("stack_status", want.stack_status, rsp_payload.stack_status);
            check_field("target_slot", want.target_slot, rsp_payload.target_slot);
            check_field("slot_found", want.slot_found, rsp_payload.slot_found);
            check_field("pump_drive", want.pump_drive, rsp_payload.pump_drive);
            check_field("valve_drive", want.valve_drive, rsp_payload.valve_drive);
            check_field("occupied_count", want.occupied_count, rsp_payload.occupied_count);
            check_field("occupied_mask", want.occupied_mask, rsp_payload.occupied_mask);
            check_field("grab_type", want.grab_type, rsp_payload.grab_type);
            check_field("queried_type", want.queried_type, rsp_payload.queried_type);
         end
      end
   end

   task automatic queue_cmd(input logic [2:0] k, input logic [3:0] s, input logic dis,
                            input logic [1:0] ty);
      req_payload_type c;
      c.kind = k;
      c.sensor_levels = s;
      c.machine_disabled = dis;
      c.item_type = ty;
      c.query_slot = 2'($urandom_range(3));
      slot_cmd_queue.push_back(c);
      items_queued++;
   endtask

   task automatic queue_req(input logic [2:0] k);
      queue_cmd(k, 4'($urandom), 1'($urandom), 2'($urandom));
   endtask

   // long settling runs stay glitch-free so that high thresholds are reached
   task automatic queue_ticks(input int n);
      logic [3:0] s;
      repeat (n) begin
         s = sensor_now;
         if (n <= 20 && $urandom_range(99) < 5) s ^= 4'b0001 << $urandom_range(3);
         queue_cmd(KIND_TICK, s, 1'b0, 2'($urandom));
      end
   endtask

   task automatic queue_random(input int budget);
      int start;
      int top;
      int pick;
      int i;
      start = items_queued;
      while (items_queued - start < budget) begin
         pick = $urandom_range(99);
         top = -1;
         for (i = 0; i < NUM_SLOTS; i++) if (!sensor_now[i]) top = i;
         if (pick < 38) begin
            if ($urandom_range(2) == 0) queue_req(KIND_SET_TYPE);
            queue_req(KIND_PUSH_REQ);
            queue_req($urandom_range(4) == 0 ? KIND_CANCEL_PUSH : KIND_CONFIRM_PUSH);
            if (top < NUM_SLOTS - 1) sensor_now[top + 1] = 1'b0;
            queue_ticks(int'(fill_thr) + $urandom_range(1, 2));
         end else if (pick < 68) begin
            queue_req(KIND_POP_REQ);
            if ($urandom_range(5) != 0) queue_req(KIND_CONFIRM_POP);
            if (top >= 0) sensor_now[top] = 1'b1;
            queue_ticks(int'(drain_thr) + $urandom_range(1, 2));
         end else if (pick < 84) begin
            repeat ($urandom_range(1, 3))
               queue_cmd(3'($urandom), 4'($urandom), 1'($urandom), 2'($urandom));
         end else if (pick < 96) begin
            sensor_now = 4'($urandom);
            queue_ticks($urandom_range(1, 6));
         end else begin
            queue_cmd(KIND_TICK, sensor_now, 1'b1, 2'($urandom));
         end
      end
   endtask

   // sampled at the falling edge so that driver updates have settled
   task automatic wait_drained();
      do
         @(negedge clock);
      while (slot_cmd_queue.size() != 0 || req_valid || expected_stack_rsp.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FILL_THRESHOLD) fill_thr = val;
      else if (idx == CSR_DRAIN_THRESHOLD) drain_thr = val;
   endtask

   task automatic run_phase(input logic [THR_W-1:0] fill, input logic [THR_W-1:0] drain,
                            input int budget, input logic with_hold);
      write_reg(CSR_FILL_THRESHOLD, fill);
      write_reg(CSR_DRAIN_THRESHOLD, drain);
      queue_random(budget);
      if (with_hold) begin
         @(posedge clock);
         hold_pending <= 1'b1;
         wait_drained();
         queue_random(budget);
      end
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 12;
      recv_stall_pct = 76;
      write_reg(CSR_SPARE_INDEX, 8'hFF);
      write_reg(CSR_FILL_THRESHOLD, 8'd1);
      write_reg(CSR_DRAIN_THRESHOLD, 8'd2);
      queue_req(KIND_POP_REQ);
      queue_req(KIND_PUSH_REQ);
      queue_cmd(KIND_TICK, 4'hF, 1'b0, 2'd0);
      queue_cmd(KIND_TICK, 4'h0, 1'b0, 2'd3);
      queue_req(KIND_PUSH_REQ);
      queue_req(KIND_POP_REQ);
      queue_cmd(KIND_SET_TYPE, 4'hF, 1'b1, 2'd3);
      queue_req(KIND_CONFIRM_PUSH);
      queue_cmd(KIND_SPARE, 4'h0, 1'b1, 2'd3);
      queue_cmd(KIND_TICK, 4'h8, 1'b0, 2'd0);
      queue_cmd(KIND_TICK, 4'h8, 1'b0, 2'd1);
      queue_req(KIND_POP_REQ);
      queue_cmd(KIND_SET_TYPE, 4'h0, 1'b0, 2'd2);
      queue_req(KIND_CONFIRM_PUSH);
      queue_req(KIND_CONFIRM_POP);
      queue_req(KIND_PUSH_REQ);
      queue_req(KIND_CONFIRM_PUSH);
      queue_req(KIND_CANCEL_PUSH);
      queue_cmd(KIND_SET_TYPE, 4'hA, 1'b1, 2'd0);
      queue_cmd(KIND_TICK, 4'h0, 1'b1, 2'd1);
      queue_cmd(KIND_TICK, 4'h5, 1'b0, 2'd2);
      queue_req(KIND_POP_REQ);
      sensor_now = 4'h5;
      wait_drained();

      run_phase(8'd10, 8'd10, 80, 1'b0);
      run_phase(8'd1, 8'd1, 80, 1'b0);
      run_phase(8'd3, 8'd2, 80, 1'b0);

      send_idle_pct = 76;
      recv_stall_pct = 12;
      run_phase(8'd0, 8'd0, 60, 1'b0);
      run_phase(8'd2, 8'd5, 80, 1'b0);
      run_phase(8'd255, 8'd1, 1, 1'b0);
      run_phase(8'd1, 8'd255, 1, 1'b0);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_phase(8'd4, 8'd4, 40, 1'b1);

      if (mismatch_count == 0) begin
         $display("tb_debounced_slot_stack_controller: done, clean");
      end else begin
         $display("tb_debounced_slot_stack_controller: done, errors");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("tb_debounced_slot_stack_controller: done, errors");
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/dssc_pkg.sv
sv/dssc_slot_lane.sv
sv/dssc_merge.sv
sv/debounced_slot_stack_controller.sv
dv/tb_debounced_slot_stack_controller.sv
